### sv/bpa_pkg.sv
// shared constants, codes and controller/datapath interface types for the page allocator
package bpa_pkg;

    localparam int DEF_NUM_SLOTS  = 1024;
    localparam int DEF_COUNT_BITS = 16;

    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;
    localparam int ACT_W     = 3;
    localparam int PAGE_W    = 10;
    localparam int STATUS_W  = 2;

    localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FREE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_GET   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_PUT   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DEL   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic clear;
        logic latch;
        logic scan_first;
        logic scan_next;
        logic alloc_commit;
        logic op_read;
        logic exec_commit;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic hit;
        logic last;
    } t_stat;

endpackage

### sv/bitmap_page_allocator_refcount_core.sv
// top level of the page slot allocator with reference counts
//
// Input channel (i_in_valid / o_in_ready) carries one request beat: i_action and i_page.
// Output channel (o_out_valid / i_out_ready) returns one result beat per request:
// o_slot, o_status and o_released, held in an output register until taken.
// Allocate scans the used-slot bitmap one 64-bit word per cycle through a single
// read port and stops at the first word with a free slot, or after the last word
// when the bitmap is full. Free, get, put and delete read the bitmap word and the
// count entry, then update whichever of the two the operation changes. A new
// request is taken once the previous one has committed.
// After reset a clearing pass writes every bitmap word and every count/mark entry,
// with o_in_ready low throughout.
// A stalled output beat holds its payload; a following request may be accepted
// meanwhile, but it does not commit until the output register has been drained.
module bitmap_page_allocator_refcount_core #(
    parameter int NUM_SLOTS  = bpa_pkg::DEF_NUM_SLOTS,
    parameter int COUNT_BITS = bpa_pkg::DEF_COUNT_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [bpa_pkg::ACT_W-1:0]    i_action,
    input  logic [bpa_pkg::PAGE_W-1:0]   i_page,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [bpa_pkg::PAGE_W-1:0]   o_slot,
    output logic [bpa_pkg::STATUS_W-1:0] o_status,
    output logic                         o_released
);
    import bpa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    bpa_dp #(
        .NUM_SLOTS  (NUM_SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_action   (i_action),
        .i_page     (i_page),
        .o_slot     (o_slot),
        .o_status   (o_status),
        .o_released (o_released)
    );

endmodule

### sv/bpa_ctrl.sv
// sequencer for clearing, bitmap scan and single-page operations
module bpa_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [bpa_pkg::ACT_W-1:0] i_action,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output bpa_pkg::t_cmd             o_cmd,
    input  bpa_pkg::t_stat            i_stat
);
    import bpa_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN0 = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_EXEC  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;
    logic       load;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = (i_action == ACT_ALLOC) ? S_SCAN0 : S_RD;
                end
            end
            S_SCAN0: begin
                o_cmd.scan_first = 1'b1;
                n_state          = S_SCAN;
            end
            S_SCAN: begin
                // stop on a free bit or after the last word, hold while the result slot is busy
                if (i_stat.hit || i_stat.last) begin
                    if (out_free) begin
                        o_cmd.alloc_commit = 1'b1;
                        n_state            = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_RD: begin
                o_cmd.op_read = 1'b1;
                n_state       = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    o_cmd.exec_commit = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign load = o_cmd.alloc_commit || o_cmd.exec_commit;

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### sv/bpa_dp.sv
// bitmap and reference-count memories, scan logic, page update logic and result register
module bpa_dp #(
    parameter int NUM_SLOTS  = bpa_pkg::DEF_NUM_SLOTS,
    parameter int COUNT_BITS = bpa_pkg::DEF_COUNT_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bpa_pkg::t_cmd                i_cmd,
    output bpa_pkg::t_stat               o_stat,
    input  logic [bpa_pkg::ACT_W-1:0]    i_action,
    input  logic [bpa_pkg::PAGE_W-1:0]   i_page,
    output logic [bpa_pkg::PAGE_W-1:0]   o_slot,
    output logic [bpa_pkg::STATUS_W-1:0] o_status,
    output logic                         o_released
);
    import bpa_pkg::*;

    localparam int WORD_COUNT = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int ADDR_W     = $clog2(NUM_SLOTS);
    localparam int LAST_TOP   = NUM_SLOTS - (WORD_COUNT - 1) * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        (LAST_TOP >= WORD_BITS) ? '1 : ((64'd1 << LAST_TOP) - 64'd1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    function automatic logic [BIT_W-1:0] onehot_idx(input logic [WORD_BITS-1:0] oh);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (oh[i]) begin
                idx = idx | BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // memories
    logic [WORD_BITS-1:0]  r_words [WORD_COUNT];
    logic [COUNT_BITS:0]   r_refs  [NUM_SLOTS];

    logic [ACT_W-1:0]      r_act;
    logic [PAGE_W-1:0]     r_page;
    logic [ADDR_W-1:0]     r_clr;
    logic [WORD_W-1:0]     r_dw;
    logic [WORD_BITS-1:0]  r_wdata;
    logic [COUNT_BITS:0]   r_cdata;
    logic [PAGE_W-1:0]     r_slot;
    logic [STATUS_W-1:0]   r_status;
    logic                  r_released;

    // page decode
    logic [31:0]           page_wide;
    logic                  page_oor;
    logic [ADDR_W-1:0]     page_addr;
    logic [WORD_W-1:0]     page_word;
    logic [BIT_W-1:0]      page_bit;

    // scan
    logic [WORD_BITS-1:0]  scan_mask;
    logic [WORD_BITS-1:0]  free_bits;
    logic [WORD_BITS-1:0]  free_one;
    logic [BIT_W-1:0]      free_idx;
    logic                  hit;
    logic                  last;
    logic [WORD_W+BIT_W-1:0] alloc_full;
    logic [31:0]           alloc_wide;
    logic [ADDR_W-1:0]     alloc_addr;
    logic [WORD_W-1:0]     dw_inc;

    // page operation
    logic                  used;
    logic [COUNT_BITS-1:0] cnt;
    logic                  mark;
    logic [WORD_BITS-1:0]  page_one;
    logic [STATUS_W-1:0]   x_status;
    logic                  x_rel;
    logic                  x_wword_en;
    logic [WORD_BITS-1:0]  x_wword;
    logic                  x_wref_en;
    logic [COUNT_BITS:0]   x_wref;

    // memory ports
    logic                  w_we;
    logic [WORD_W-1:0]     w_waddr;
    logic [WORD_BITS-1:0]  w_wdata;
    logic                  w_re;
    logic [WORD_W-1:0]     w_raddr;
    logic                  c_we;
    logic [ADDR_W-1:0]     c_waddr;
    logic [COUNT_BITS:0]   c_wdata;
    logic                  c_re;
    logic                  clr_word;

    assign page_wide = 32'(r_page);
    assign page_oor  = page_wide >= 32'(NUM_SLOTS);
    assign page_addr = page_wide[ADDR_W-1:0];
    assign page_word = page_wide[WORD_W+BIT_W-1:BIT_W];
    assign page_bit  = r_page[BIT_W-1:0];

    assign last       = (32'(r_dw) == 32'(WORD_COUNT - 1));
    assign scan_mask  = last ? LAST_MASK : '1;
    assign free_bits  = ~r_wdata & scan_mask;
    assign hit        = |free_bits;
    // isolate the lowest free bit
    assign free_one   = free_bits & (~free_bits + 64'd1);
    assign free_idx   = onehot_idx(free_one);
    assign alloc_full = {r_dw, free_idx};
    assign alloc_wide = 32'(alloc_full);
    assign alloc_addr = alloc_full[ADDR_W-1:0];
    assign dw_inc     = WORD_W'(r_dw + 1'b1);

    assign o_stat.clr_done = (r_clr == ADDR_W'(NUM_SLOTS - 1));
    assign o_stat.hit      = hit;
    assign o_stat.last     = last;

    assign used     = r_wdata[page_bit];
    assign cnt      = r_cdata[COUNT_BITS-1:0];
    assign mark     = r_cdata[COUNT_BITS];
    assign page_one = 64'd1 << page_bit;

    always_comb begin
        x_status   = ST_OK;
        x_rel      = 1'b0;
        x_wword_en = 1'b0;
        x_wword    = r_wdata & ~page_one;
        x_wref_en  = 1'b0;
        x_wref     = r_cdata;
        if (r_act > ACT_DEL || page_oor) begin
            x_status = ST_BAD;
        end else begin
            case (r_act)
                ACT_FREE: begin
                    x_wword_en = 1'b1;
                    x_rel      = used;
                end
                ACT_GET: begin
                    if (!used || cnt == COUNT_MAX) begin
                        x_status = ST_BAD;
                    end else begin
                        x_wref_en = 1'b1;
                        x_wref    = {mark, cnt + COUNT_BITS'(1)};
                    end
                end
                ACT_PUT: begin
                    if (cnt == '0) begin
                        x_status = ST_BAD;
                    end else begin
                        x_wref_en = 1'b1;
                        x_wref    = {mark, cnt - COUNT_BITS'(1)};
                        // last reference gone on a deleted page
                        if (cnt == COUNT_BITS'(1) && mark) begin
                            x_wword_en = 1'b1;
                            x_rel      = used;
                        end
                    end
                end
                ACT_DEL: begin
                    x_wref_en = 1'b1;
                    x_wref    = {1'b1, cnt};
                end
                default: begin
                end
            endcase
        end
    end

    assign clr_word = i_cmd.clear && (32'(r_clr) < 32'(WORD_COUNT));

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_dw;
        w_wdata = r_wdata | free_one;
        if (clr_word) begin
            w_we    = 1'b1;
            w_waddr = r_clr[WORD_W-1:0];
            w_wdata = '0;
        end else if (i_cmd.alloc_commit && hit) begin
            w_we = 1'b1;
        end else if (i_cmd.exec_commit && x_wword_en) begin
            w_we    = 1'b1;
            w_waddr = page_word;
            w_wdata = x_wword;
        end
    end

    always_comb begin
        w_re    = 1'b0;
        w_raddr = page_word;
        if (i_cmd.scan_first) begin
            w_re    = 1'b1;
            w_raddr = '0;
        end else if (i_cmd.scan_next) begin
            w_re    = 1'b1;
            w_raddr = dw_inc;
        end else if (i_cmd.op_read && !page_oor) begin
            w_re = 1'b1;
        end
    end

    always_comb begin
        c_we    = 1'b0;
        c_waddr = page_addr;
        c_wdata = x_wref;
        if (i_cmd.clear) begin
            c_we    = 1'b1;
            c_waddr = r_clr;
            c_wdata = '0;
        end else if (i_cmd.alloc_commit && hit) begin
            c_we    = 1'b1;
            c_waddr = alloc_addr;
            c_wdata = {1'b0, COUNT_BITS'(1)};
        end else if (i_cmd.exec_commit && x_wref_en) begin
            c_we = 1'b1;
        end
    end

    assign c_re = i_cmd.op_read && !page_oor;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_words[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_wdata <= r_words[w_raddr];
        end
        if (c_we) begin
            r_refs[c_waddr] <= c_wdata;
        end
        if (c_re) begin
            r_cdata <= r_refs[page_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_dw  <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.scan_first) begin
                r_dw <= '0;
            end else if (i_cmd.scan_next) begin
                r_dw <= dw_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_act  <= i_action;
            r_page <= i_page;
        end
        if (i_cmd.alloc_commit) begin
            r_slot     <= hit ? alloc_wide[PAGE_W-1:0] : '0;
            r_status   <= hit ? ST_OK : ST_FULL;
            r_released <= 1'b0;
        end else if (i_cmd.exec_commit) begin
            r_slot     <= r_page;
            r_status   <= x_status;
            r_released <= x_rel;
        end
    end

    assign o_slot     = r_slot;
    assign o_status   = r_status;
    assign o_released = r_released;

endmodule
